>>> sv/scdl_pkg.sv
// Shared types and constants of the sector cache tag directory.
package scdl_pkg;

  localparam int unsigned ENTRIES   = 8;
  localparam int unsigned IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned SLOT_W    = 3;
  localparam int unsigned DRIVE_W   = 8;
  localparam int unsigned SECTOR_W  = 32;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned STAMP_W   = 32;
  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_FILL   = 2'd1,
    REQ_INVAL  = 2'd2,
    REQ_RSVD   = 2'd3
  } req_kind_t;

  typedef struct packed {
    req_kind_t             kind;
    logic [DRIVE_W-1:0]    drive;
    logic [SECTOR_W-1:0]   sector;
    logic [SECTOR_W-1:0]   top;
  } cell_req_t;

  typedef struct packed {
    logic wr_tag;
    logic wr_stamp;
    logic inval;
  } cell_cmd_t;

  typedef struct packed {
    logic               found;
    logic [IDX_W-1:0]   idx;
    logic               old_found;
    logic [IDX_W-1:0]   old_idx;
    logic [STAMP_W-1:0] best;
  } scan_carry_t;

  localparam scan_carry_t CARRY_INIT = '{
    found: 1'b0, idx: '0, old_found: 1'b0, old_idx: '0, best: STAMP_MAX
  };

endpackage

>>> sv/scdl_ifs.sv
// Valid/ready channel interfaces for requests and responses.
interface scdl_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     req_type;
  logic [scdl_pkg::DRIVE_W-1:0]   drive;
  logic [scdl_pkg::SECTOR_W-1:0]  sector;
  logic [scdl_pkg::COUNT_W-1:0]   count;

  modport source (output valid, req_type, drive, sector, count, input ready);
  modport sink   (input valid, req_type, drive, sector, count, output ready);
endinterface

interface scdl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [scdl_pkg::SLOT_W-1:0]   slot;
  logic                          stored;

  modport source (output valid, hit, slot, stored, input ready);
  modport sink   (input valid, hit, slot, stored, output ready);
endinterface

>>> sv/scdl_cell.sv
// One directory entry with its stage of the registered search chain.
module scdl_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [scdl_pkg::IDX_W-1:0]    cell_idx,
  input  scdl_pkg::cell_req_t           req,
  input  scdl_pkg::cell_cmd_t           cmd,
  input  logic                          sel,
  input  logic [scdl_pkg::STAMP_W-1:0]  stamp,
  input  scdl_pkg::scan_carry_t         carry_in,
  output scdl_pkg::scan_carry_t         carry_out
);

  logic                           valid_r;
  logic [scdl_pkg::DRIVE_W-1:0]   drive_r;
  logic [scdl_pkg::SECTOR_W-1:0]  sector_r;
  logic [scdl_pkg::STAMP_W-1:0]   stamp_r;
  scdl_pkg::scan_carry_t          carry_r;
  scdl_pkg::scan_carry_t          carry_nxt;
  logic                           tag_eq;
  logic                           in_range;

  assign tag_eq   = (drive_r == req.drive) && (sector_r == req.sector);
  assign in_range = (drive_r == req.drive) && (sector_r >= req.sector) &&
                    (sector_r < req.top);

  always_comb begin
    carry_nxt = carry_in;
    if (!carry_in.found) begin
      if (((req.kind == scdl_pkg::REQ_LOOKUP) && valid_r && tag_eq) ||
          ((req.kind == scdl_pkg::REQ_FILL) && !valid_r)) begin
        carry_nxt.found = 1'b1;
        carry_nxt.idx   = cell_idx;
      end
    end
    if ((req.kind == scdl_pkg::REQ_FILL) && valid_r && (stamp_r < carry_in.best)) begin
      carry_nxt.best      = stamp_r;
      carry_nxt.old_found = 1'b1;
      carry_nxt.old_idx   = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (sel && cmd.wr_tag) begin
      valid_r <= 1'b1;
    end else if (cmd.inval && valid_r && in_range) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
    if (sel && cmd.wr_tag) begin
      drive_r  <= req.drive;
      sector_r <= req.sector;
    end
    if (sel && (cmd.wr_tag || cmd.wr_stamp)) begin
      stamp_r <= stamp;
    end
  end

  assign carry_out = carry_r;

endmodule

>>> sv/sector_cache_directory_lru_top.sv
// Top level of the sector cache tag directory with LRU replacement.
// A request transaction is taken only in the idle state; the search then passes one
// cell of the chain per cycle, the update state writes the chosen entry once the
// response register is free (a held response stalls it), and the block returns to
// idle to take the next request transaction, so requests do not overlap.
// Reset: synchronous, active low; clears all valid bits and the access counter.
module sector_cache_directory_lru_top (
  input  logic         clk,
  input  logic         rst_n,
  scdl_req_if.sink     in_req,
  scdl_rsp_if.source   out_rsp
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

  state_t                            state_r;
  logic [scdl_pkg::IDX_W-1:0]        scan_cnt_r;
  scdl_pkg::cell_req_t               req_r;
  logic [scdl_pkg::STAMP_W-1:0]      access_count_r;
  logic [scdl_pkg::STAMP_W-1:0]      access_count_nxt;
  logic                              out_valid_r;
  logic                              out_hit_r;
  logic [scdl_pkg::SLOT_W-1:0]       out_slot_r;
  logic                              out_stored_r;

  scdl_pkg::scan_carry_t             chain [scdl_pkg::ENTRIES+1];
  scdl_pkg::scan_carry_t             result;
  scdl_pkg::cell_cmd_t               cmd;
  logic [scdl_pkg::IDX_W-1:0]        pick_idx;
  logic                              do_apply;
  logic                              do_write;
  logic                              lookup_hit;
  logic                              fill_ok;
  logic                              out_free;

  assign chain[0] = scdl_pkg::CARRY_INIT;
  assign result   = chain[scdl_pkg::ENTRIES];

  for (genvar i = 0; i < scdl_pkg::ENTRIES; i++) begin : g_cell
    logic sel;
    assign sel = (pick_idx == scdl_pkg::IDX_W'(i));
    scdl_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (scdl_pkg::IDX_W'(i)),
      .req       (req_r),
      .cmd       (cmd),
      .sel       (sel),
      .stamp     (access_count_nxt),
      .carry_in  (chain[i]),
      .carry_out (chain[i+1])
    );
  end

  assign out_free   = !out_valid_r || out_rsp.ready;
  assign do_apply   = (state_r == ST_APPLY) && out_free;
  assign lookup_hit = (req_r.kind == scdl_pkg::REQ_LOOKUP) && result.found;
  assign fill_ok    = (req_r.kind == scdl_pkg::REQ_FILL) &&
                      (result.found || result.old_found);
  assign pick_idx   = result.found ? result.idx : result.old_idx;
  assign do_write   = do_apply && (lookup_hit || fill_ok);
  assign access_count_nxt = access_count_r + scdl_pkg::STAMP_W'(1);

  always_comb begin
    cmd.wr_tag   = do_apply && fill_ok;
    cmd.wr_stamp = do_apply && lookup_hit;
    cmd.inval    = do_apply && (req_r.kind == scdl_pkg::REQ_INVAL);
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      req_r.kind   <= scdl_pkg::req_kind_t'(in_req.req_type);
      req_r.drive  <= in_req.drive;
      req_r.sector <= in_req.sector;
      req_r.top    <= in_req.sector + scdl_pkg::SECTOR_W'(in_req.count);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      scan_cnt_r     <= '0;
      access_count_r <= '0;
      out_valid_r    <= 1'b0;
      out_hit_r      <= 1'b0;
      out_slot_r     <= '0;
      out_stored_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_rsp.ready && !do_apply) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_req.valid) begin
            state_r    <= ST_SCAN;
            scan_cnt_r <= '0;
          end
        end
        ST_SCAN: begin
          if (scan_cnt_r == scdl_pkg::IDX_W'(scdl_pkg::ENTRIES - 1)) begin
            state_r <= ST_APPLY;
          end else begin
            scan_cnt_r <= scan_cnt_r + scdl_pkg::IDX_W'(1);
          end
        end
        ST_APPLY: begin
          if (out_free) begin
            state_r      <= ST_IDLE;
            out_valid_r  <= 1'b1;
            out_hit_r    <= lookup_hit;
            out_stored_r <= fill_ok;
            out_slot_r   <= (lookup_hit || fill_ok) ? scdl_pkg::SLOT_W'(pick_idx) : '0;
            if (do_write) begin
              access_count_r <= access_count_nxt;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_req.ready   = (state_r == ST_IDLE);
  assign out_rsp.valid  = out_valid_r;
  assign out_rsp.hit    = out_hit_r;
  assign out_rsp.slot   = out_slot_r;
  assign out_rsp.stored = out_stored_r;

  a_rsp_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_APPLY))
    else $error("response raised outside the update cycle");

  a_count_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(access_count_r)) |-> $past(do_write))
    else $error("access counter moved without an entry write");

  a_hit_xor_stored: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({out_hit_r, out_stored_r}))
    else $error("response reports both hit and stored");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |=> (state_r == ST_SCAN || state_r == ST_APPLY))
    else $error("search left before reaching the update cycle");

endmodule

>>> tb/sv/tb_sector_cache_directory_lru_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sector cache tag directory with LRU replacement.
module tb_sector_cache_directory_lru_top;
  import scdl_pkg::*;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              stored;
  } dir_rsp_t;

  // Tag directory predictor plus in-order store of outstanding responses.
  class tag_dir_scoreboard;
    logic                slot_valid  [ENTRIES];
    logic [DRIVE_W-1:0]  slot_drive  [ENTRIES];
    logic [SECTOR_W-1:0] slot_sector [ENTRIES];
    logic [STAMP_W-1:0]  slot_stamp  [ENTRIES];
    logic [STAMP_W-1:0]  access_count;
    dir_rsp_t            outstanding[$];
    int unsigned         failures;

    function new();
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      access_count = '0;
      failures     = 0;
    endfunction

    function void note_request(input req_kind_t kind, input logic [DRIVE_W-1:0] drv,
                               input logic [SECTOR_W-1:0] sec,
                               input logic [COUNT_W-1:0] cnt);
      dir_rsp_t            r;
      int                  pick;
      int                  oldest;
      logic [STAMP_W-1:0]  best;
      logic [SECTOR_W-1:0] top;
      r      = '0;
      pick   = -1;
      oldest = -1;
      best   = STAMP_MAX;
      top    = sec + SECTOR_W'(cnt);
      case (kind)
        REQ_LOOKUP: begin
          for (int i = 0; i < ENTRIES && pick < 0; i++)
            if (slot_valid[i] && slot_drive[i] == drv && slot_sector[i] == sec) pick = i;
          if (pick >= 0) begin
            access_count     = access_count + STAMP_W'(1);
            slot_stamp[pick] = access_count;
            r.hit            = 1'b1;
            r.slot           = pick[SLOT_W-1:0];
          end
        end
        REQ_FILL: begin
          // lowest free slot first, else strictly smallest stamp
          for (int i = 0; i < ENTRIES && pick < 0; i++) begin
            if (!slot_valid[i]) begin
              pick = i;
            end else if (slot_stamp[i] < best) begin
              best   = slot_stamp[i];
              oldest = i;
            end
          end
          if (pick < 0) pick = oldest;
          if (pick >= 0) begin
            access_count      = access_count + STAMP_W'(1);
            slot_valid[pick]  = 1'b1;
            slot_drive[pick]  = drv;
            slot_sector[pick] = sec;
            slot_stamp[pick]  = access_count;
            r.stored          = 1'b1;
            r.slot            = pick[SLOT_W-1:0];
          end
        end
        REQ_INVAL: begin
          foreach (slot_valid[i])
            if (slot_valid[i] && slot_drive[i] == drv &&
                slot_sector[i] >= sec && slot_sector[i] < top)
              slot_valid[i] = 1'b0;
        end
        default: ;
      endcase
      outstanding.push_back(r);
    endfunction

    function void check_response(input logic hit, input logic [SLOT_W-1:0] slot,
                                 input logic stored);
      dir_rsp_t want;
      if (outstanding.size() == 0) begin
        $display("%0t: unexpected response hit=%0b slot=%0d stored=%0b",
                 $time, hit, slot, stored);
        failures++;
        return;
      end
      want = outstanding.pop_front();
      if (hit !== want.hit) begin
        $display("%0t: hit mismatch: expected %0b, actual %0b", $time, want.hit, hit);
        failures++;
      end
      if (slot !== want.slot) begin
        $display("%0t: slot mismatch: expected %0d, actual %0d", $time, want.slot, slot);
        failures++;
      end
      if (stored !== want.stored) begin
        $display("%0t: stored mismatch: expected %0b, actual %0b",
                 $time, want.stored, stored);
        failures++;
      end
    endfunction

    function int pending_count();
      return outstanding.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   idle_en     = 1'b1;
  bit   hold_off_go = 1'b0;

  tag_dir_scoreboard sb;

  scdl_req_if req_ch ();
  scdl_rsp_if rsp_ch ();

  sector_cache_directory_lru_top u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #3ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_req(input req_kind_t kind, input logic [DRIVE_W-1:0] drv,
                          input logic [SECTOR_W-1:0] sec, input logic [COUNT_W-1:0] cnt);
    if (idle_en && $urandom_range(0, 99) < 12) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.drive    <= drv;
    req_ch.sector   <= sec;
    req_ch.count    <= cnt;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(kind, drv, sec, cnt);
    @(negedge clk);
  endtask

  // response side: random back-pressure plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left    = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_go) begin
        hold_off_go = 1'b0;
        hold_left   = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= !(idle_en && $urandom_range(0, 99) < 12);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready)
      sb.check_response(rsp_ch.hit, rsp_ch.slot, rsp_ch.stored);
  end

  initial begin
    int                  n;
    int                  r;
    req_kind_t           kind;
    logic [DRIVE_W-1:0]  drv;
    logic [SECTOR_W-1:0] sec;
    logic [COUNT_W-1:0]  cnt;
    logic [SECTOR_W-1:0] hot_sector [12];
    logic [DRIVE_W-1:0]  hot_drive  [3];
    logic [SECTOR_W-1:0] base;

    sb              = new();
    rst_n           = 1'b0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_LOOKUP;
    req_ch.drive    = '0;
    req_ch.sector   = '0;
    req_ch.count    = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty miss, fill all slots with extreme tags, hits, misses
    send_req(REQ_LOOKUP, 8'd0,   32'h0000_0000, 8'd0);
    send_req(REQ_FILL,   8'd0,   32'h0000_0000, 8'd0);
    send_req(REQ_FILL,   8'd255, 32'hFFFF_FFFF, 8'd0);
    send_req(REQ_FILL,   8'd0,   32'hFFFF_FFFF, 8'd0);
    send_req(REQ_FILL,   8'd255, 32'h0000_0000, 8'd0);
    send_req(REQ_FILL,   8'd1,   32'd5,         8'd0);
    send_req(REQ_FILL,   8'd1,   32'd6,         8'd0);
    send_req(REQ_FILL,   8'd1,   32'd7,         8'd0);
    send_req(REQ_FILL,   8'd1,   32'd8,         8'd0);
    send_req(REQ_LOOKUP, 8'd255, 32'hFFFF_FFFF, 8'd0);
    send_req(REQ_LOOKUP, 8'd0,   32'h0000_0000, 8'd0);
    send_req(REQ_LOOKUP, 8'd1,   32'h0000_0000, 8'd0);
    send_req(REQ_LOOKUP, 8'd0,   32'd5,         8'd0);
    // full directory: LRU victim
    send_req(REQ_FILL,   8'd2,   32'd100,       8'd0);
    // zero count, normal range, wrapping ends
    send_req(REQ_INVAL,  8'd1,   32'd5,         8'd0);
    send_req(REQ_INVAL,  8'd1,   32'd5,         8'd3);
    send_req(REQ_INVAL,  8'd0,   32'hFFFF_FFF0, 8'd255);
    send_req(REQ_INVAL,  8'd255, 32'hFFFF_FFFF, 8'd1);
    send_req(REQ_INVAL,  8'd255, 32'h0000_0000, 8'd255);
    send_req(REQ_RSVD,   8'd255, 32'hFFFF_FFFF, 8'd255);
    send_req(REQ_FILL,   8'd3,   32'd1,         8'd0);
    send_req(REQ_LOOKUP, 8'd1,   32'd8,         8'd0);
    send_req(REQ_LOOKUP, 8'd255, 32'h0000_0000, 8'd0);

    // random: small tag pool so hits, evictions and range clears recur
    base          = $urandom;
    hot_sector[0] = 32'h0000_0000;
    hot_sector[1] = 32'hFFFF_FFFF;
    hot_sector[2] = 32'hFFFF_FFFE;
    for (int k = 3; k < 8; k++) hot_sector[k] = base + k - 3;
    for (int k = 8; k < 12; k++) hot_sector[k] = k * 3;
    hot_drive[0] = 8'd0;
    hot_drive[1] = 8'd255;
    hot_drive[2] = 8'($urandom);

    for (n = 0; n < 600; n++) begin
      idle_en = !(n >= 250 && n < 380);
      if (n == 450) hold_off_go = 1'b1;
      r   = $urandom_range(0, 99);
      drv = ($urandom_range(0, 9) == 0) ? 8'($urandom) : hot_drive[$urandom_range(0, 2)];
      sec = hot_sector[$urandom_range(0, 11)];
      cnt = 8'($urandom_range(0, 4));
      if (r < 10) begin
        kind = req_kind_t'($urandom_range(0, 3));
        drv  = 8'($urandom);
        sec  = $urandom;
        cnt  = 8'($urandom);
      end else if (r < 50) begin
        kind = REQ_LOOKUP;
      end else if (r < 82) begin
        kind = REQ_FILL;
      end else begin
        kind = REQ_INVAL;
        sec  = sec - $urandom_range(0, 2);
        if ($urandom_range(0, 4) == 0) cnt = 8'($urandom);
      end
      send_req(kind, drv, sec, cnt);
    end
    req_ch.valid <= 1'b0;
    idle_en = 1'b1;

    while (sb.pending_count() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
